// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);

    // fixed field widths of the ports
    localparam int CELL_AW = 11;
    localparam int CH_W    = 8;
    localparam int TAB_W   = 4;

    // special characters
    localparam logic [CH_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CH_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CH_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CH_W-1:0] CH_SPACE     = 8'd32;

    // register reset values
    localparam logic [TAB_W-1:0] TAB_LENGTH_RESET = 4'd4;
    localparam logic [CH_W-1:0]  TAB_FILL_RESET   = 8'd32;

    // configuration register indexes
    localparam logic [0:0] CFG_TAB_LENGTH = 1'b0;
    localparam logic [0:0] CFG_TAB_FILL   = 1'b1;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        logic [CH_W-1:0] color;
        logic [CH_W-1:0] ch;
    } cell_t;

    // one write and one read access per cycle
    typedef struct packed {
        logic              wr_en;
        logic              wr_direct;
        logic [ADDR_W-1:0] wr_addr;
        cell_t             wr_cell;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage

// ===== rtl/core/tcw_screen_mem.sv =====
module tcw_screen_mem (
    input  logic                         clk,
    input  tcw_pkg::mem_req_t            req,
    input  logic [tcw_pkg::ADDR_W-1:0]   base,
    output tcw_pkg::cell_t               rd_cell
);
    import tcw_pkg::*;

    // logical cell index to physical slot of the row ring
    function automatic logic [ADDR_W-1:0] ring_map(
        input logic [ADDR_W-1:0] addr,
        input logic [ADDR_W-1:0] offs
    );
        logic [ADDR_W:0] sum;
        sum = {1'b0, addr} + {1'b0, offs};
        if (sum >= (ADDR_W+1)'(CELL_COUNT))
        begin
            sum = sum - (ADDR_W+1)'(CELL_COUNT);
        end
        return sum[ADDR_W-1:0];
    endfunction

    cell_t             cells [CELL_COUNT];
    cell_t             rd_cell_reg;
    logic [ADDR_W-1:0] wr_slot;
    logic [ADDR_W-1:0] rd_slot;

    assign wr_slot = req.wr_direct ? req.wr_addr : ring_map(req.wr_addr, base);
    assign rd_slot = ring_map(req.rd_addr, base);

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            cells[wr_slot] <= req.wr_cell;
        end
        if (req.rd_en)
        begin
            rd_cell_reg <= cells[rd_slot];
        end
    end

    assign rd_cell = rd_cell_reg;

endmodule

// ===== rtl/core/text_console_writer.sv =====
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------------
// input     | in_valid / in_stall  | action, character, color, cell_address
// output    | out_valid / out_stall| cursor_after, cell_char, cell_color
// config    | cfg_write            | cfg_index, cfg_data
//
// one word at a time: accept, an execute state, a finish state that waits for the
// output register (plain put, read or newline); a tab adds tab_length fill cells
// (one cell write per cycle through the single memory write port, paused by a
// scroll); a scroll blanks the freed row (COLUMNS cells), a clear every cell
// after reset a clearing pass over all CELL_COUNT (2000) cells holds in_stall high
// the output register lets the next word be accepted while a result waits
module text_console_writer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [tcw_pkg::CH_W-1:0]      character,
    input  logic [tcw_pkg::CH_W-1:0]      color,
    input  logic [tcw_pkg::CELL_AW-1:0]   cell_address,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tcw_pkg::CELL_AW-1:0]   cursor_after,
    output logic [tcw_pkg::CH_W-1:0]      cell_char,
    output logic [tcw_pkg::CH_W-1:0]      cell_color,
    input  logic                          cfg_write,
    input  logic [0:0]                    cfg_index,
    input  logic [tcw_pkg::CH_W-1:0]      cfg_data
);
    import tcw_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EXEC   = 6'b000010,
        ST_TAB    = 6'b000100,
        ST_BLANK  = 6'b001000,
        ST_CLEAR  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_CELL      = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_START = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP       = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL       = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_SWEEP_ROW = ADDR_W'(COLUMNS - 1);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg, col_next;
    // physical start of logical row zero in the row ring
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] blank_base_reg, blank_base_next;
    logic [ADDR_W-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic [TAB_W-1:0]  tab_left_reg, tab_left_next;
    logic              read_hit_reg, read_hit_next;
    logic              clear_item_reg, clear_item_next;
    logic              out_valid_reg, out_valid_next;
    logic [TAB_W-1:0]  tab_len_reg;
    logic [CH_W-1:0]   tab_fill_reg;

    // accepted word
    action_t              item_action_reg;
    logic [CH_W-1:0]      item_char_reg;
    logic [CH_W-1:0]      item_color_reg;
    logic [CELL_AW-1:0]   item_addr_reg;

    // result word
    logic [CELL_AW-1:0]   out_cursor_reg;
    logic [CH_W-1:0]      out_char_reg;
    logic [CH_W-1:0]      out_color_reg;

    mem_req_t          mem_req;
    cell_t             rd_cell;
    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic              adv_en;
    logic [CH_W-1:0]   adv_ch;
    logic              scroll_en;
    logic [ADDR_W-1:0] row_start;

    assign in_accept = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign row_start = cursor_reg - ADDR_W'(col_reg);

    tcw_screen_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .base    (base_reg),
        .rd_cell (rd_cell)
    );

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        base_next       = base_reg;
        blank_base_next = blank_base_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        tab_left_next   = tab_left_reg;
        read_hit_next   = read_hit_reg;
        clear_item_next = clear_item_reg;
        out_load        = 1'b0;
        adv_en          = 1'b0;
        adv_ch          = item_char_reg;
        scroll_en       = 1'b0;
        mem_req         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next    = ST_EXEC;
                    read_hit_next = 1'b0;
                    tab_left_next = '0;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FINISH;
                unique case (item_action_reg)
                    ACT_PUT:
                    begin
                        priority if (item_char_reg == CH_TAB)
                        begin
                            if (tab_len_reg != '0)
                            begin
                                tab_left_next = tab_len_reg;
                                state_next    = ST_TAB;
                            end
                        end
                        else if (item_char_reg == CH_BACKSPACE)
                        begin
                            // ignored at the home position
                            if (cursor_reg != '0)
                            begin
                                cursor_next      = cursor_reg - 1'b1;
                                col_next         = (col_reg == '0) ? LAST_COL : col_reg - 1'b1;
                                mem_req.wr_en    = 1'b1;
                                mem_req.wr_addr  = cursor_reg - 1'b1;
                                mem_req.wr_cell  = '{color: item_color_reg, ch: CH_SPACE};
                            end
                        end
                        else if (item_char_reg == CH_NEWLINE)
                        begin
                            if (row_start == LAST_ROW_START)
                            begin
                                scroll_en = 1'b1;
                            end
                            else
                            begin
                                cursor_next = row_start + ROW_STEP;
                                col_next    = '0;
                            end
                        end
                        else
                        begin
                            adv_en = 1'b1;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        cursor_next     = '0;
                        col_next        = '0;
                        base_next       = '0;
                        sweep_cnt_next  = '0;
                        clear_item_next = 1'b1;
                        state_next      = ST_CLEAR;
                    end
                    ACT_READ:
                    begin
                        if (32'(item_addr_reg) < CELL_COUNT)
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = ADDR_W'(item_addr_reg);
                            read_hit_next   = 1'b1;
                        end
                    end
                    ACT_NONE:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_TAB:
            begin
                adv_en        = 1'b1;
                adv_ch        = tab_fill_reg;
                tab_left_next = tab_left_reg - 1'b1;
                state_next    = (tab_left_reg == TAB_W'(1)) ? ST_FINISH : ST_TAB;
            end
            ST_BLANK:
            begin
                mem_req.wr_en     = 1'b1;
                mem_req.wr_direct = 1'b1;
                mem_req.wr_addr   = blank_base_reg + sweep_cnt_reg;
                mem_req.wr_cell   = '{color: item_color_reg, ch: CH_SPACE};
                if (sweep_cnt_reg == LAST_SWEEP_ROW)
                begin
                    state_next = (tab_left_reg != '0) ? ST_TAB : ST_FINISH;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
                end
            end
            ST_CLEAR:
            begin
                // the pass after reset blanks in color zero and yields no result
                mem_req.wr_en     = 1'b1;
                mem_req.wr_direct = 1'b1;
                mem_req.wr_addr   = sweep_cnt_reg;
                mem_req.wr_cell   = '{color: (clear_item_reg ? item_color_reg : '0),
                                      ch: CH_SPACE};
                if (sweep_cnt_reg == LAST_CELL)
                begin
                    state_next      = clear_item_reg ? ST_FINISH : ST_IDLE;
                    clear_item_next = 1'b0;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // write at the cursor and step forward, scrolling at the last cell
        if (adv_en)
        begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cursor_reg;
            mem_req.wr_cell = '{color: item_color_reg, ch: adv_ch};
            if (cursor_reg == LAST_CELL)
            begin
                scroll_en = 1'b1;
            end
            else
            begin
                cursor_next = cursor_reg + 1'b1;
                col_next    = (col_reg == LAST_COL) ? '0 : col_reg + 1'b1;
            end
        end

        // rotate the row ring, then blank the row that left the top
        if (scroll_en)
        begin
            cursor_next     = LAST_ROW_START;
            col_next        = '0;
            blank_base_next = base_reg;
            base_next       = (base_reg == LAST_ROW_START) ? '0 : base_reg + ROW_STEP;
            sweep_cnt_next  = '0;
            state_next      = ST_BLANK;
        end
    end

    always_comb
    begin
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cursor_reg     <= '0;
            col_reg        <= '0;
            base_reg       <= '0;
            blank_base_reg <= '0;
            sweep_cnt_reg  <= '0;
            tab_left_reg   <= '0;
            read_hit_reg   <= 1'b0;
            clear_item_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            tab_len_reg    <= TAB_LENGTH_RESET;
            tab_fill_reg   <= TAB_FILL_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            col_reg        <= col_next;
            base_reg       <= base_next;
            blank_base_reg <= blank_base_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            tab_left_reg   <= tab_left_next;
            read_hit_reg   <= read_hit_next;
            clear_item_reg <= clear_item_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write && (cfg_index == CFG_TAB_LENGTH))
            begin
                tab_len_reg <= cfg_data[TAB_W-1:0];
            end
            if (cfg_write && (cfg_index == CFG_TAB_FILL))
            begin
                tab_fill_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_action_reg <= action_t'(action);
            item_char_reg   <= character;
            item_color_reg  <= color;
            item_addr_reg   <= cell_address;
        end
        if (out_load)
        begin
            out_cursor_reg <= CELL_AW'(cursor_reg);
            out_char_reg   <= read_hit_reg ? rd_cell.ch : '0;
            out_color_reg  <= read_hit_reg ? rd_cell.color : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cursor_after = out_cursor_reg;
    assign cell_char    = out_char_reg;
    assign cell_color   = out_color_reg;

endmodule

// ===== rtl/core/tcw_checker.sv =====
module tcw_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [tcw_pkg::CELL_AW-1:0]   cursor_after,
    input logic [tcw_pkg::CH_W-1:0]      cell_char,
    input logic [tcw_pkg::CH_W-1:0]      cell_color
);
    import tcw_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_after)
            && $stable(cell_char) && $stable(cell_color))
        else $error("stalled result word changed");

    // cursor never leaves the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(cursor_after) < CELL_COUNT))
        else $error("cursor beyond screen end");

    // one word in flight at a time
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word accepted while busy");

    // a result only comes from a word being worked on
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word without a word in flight");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
